// ===== rtl/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int HUE_W       = 16;
  localparam int UNIT_W      = FRAC_BITS + 1;
  localparam int X_W         = FRAC_BITS + HUE_W + 1;
  localparam int TOTAL_SHIFT = 2 * FRAC_BITS + HUE_W;
  localparam int NUM_W       = TOTAL_SHIFT + 1;
  localparam int BYTE_W      = 8;
  localparam int RND_W       = NUM_W + BYTE_W;
  localparam int N_STAGES    = 5;

  localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << FRAC_BITS;
  localparam logic [X_W-1:0]    X_ONE    = X_W'(1) << (FRAC_BITS + HUE_W);
  localparam logic [RND_W-1:0]  RND_HALF = RND_W'(1) << (TOTAL_SHIFT - 1);

  // hue sectors, one sixth of a turn each
  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

// ===== rtl/hsv_to_rgb_converter_top.sv =====
// HSV to RGB pixel converter. Hue is an unsigned Q0.16 fraction of a turn;
// saturation and brightness are Q12 with 4096 as one, larger values clamp to
// one. Each channel is the exact result scaled to 0..255, rounded half up.
// One pixel is accepted every clock cycle while the pipeline is not stalled:
// clamp and hue scaling, the saturation products, sector routing, the
// brightness multiply and the final rounding each take one register stage.
// Stall on the result side holds the pipeline back stage by stage, so bubbles
// close up and the input keeps being taken while any stage is empty.
module hsv_to_rgb_converter_top
  import hsv2rgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [HUE_W-1:0]  in_hue,
  input  logic [UNIT_W-1:0] in_saturation,
  input  logic [UNIT_W-1:0] in_brightness,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_red,
  output logic [BYTE_W-1:0] out_green,
  output logic [BYTE_W-1:0] out_blue
);

  logic [N_STAGES-1:0] vld_r, vld_nxt;
  logic [N_STAGES-1:0] adv;
  pipe_en_t            en;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[N_STAGES-1] = !vld_r[N_STAGES-1] || !out_stall;
    for (int i = N_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < N_STAGES; i++) begin
      if (adv[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en        = pipe_en_t'({adv[0], adv[1], adv[2], adv[3], adv[4]});
  assign in_stall  = !adv[0];
  assign out_valid = vld_r[N_STAGES-1];

  logic [UNIT_W-1:0] v3;
  logic [X_W-1:0]    xr3, xg3, xb3;

  hsv2rgb_front u_front (
    .clk        (clk),
    .en         (en),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .v_out      (v3),
    .xr_out     (xr3),
    .xg_out     (xg3),
    .xb_out     (xb3)
  );

  hsv2rgb_chan u_red (
    .clk  (clk),
    .en   (en),
    .v    (v3),
    .x    (xr3),
    .chan (out_red)
  );

  hsv2rgb_chan u_green (
    .clk  (clk),
    .en   (en),
    .v    (v3),
    .x    (xg3),
    .chan (out_green)
  );

  hsv2rgb_chan u_blue (
    .clk  (clk),
    .en   (en),
    .v    (v3),
    .x    (xb3),
    .chan (out_blue)
  );

endmodule

// ===== rtl/hsv2rgb_front.sv =====
module hsv2rgb_front
  import hsv2rgb_pkg::*;
(
  input  logic              clk,
  input  pipe_en_t          en,
  input  logic [HUE_W-1:0]  hue,
  input  logic [UNIT_W-1:0] saturation,
  input  logic [UNIT_W-1:0] brightness,
  output logic [UNIT_W-1:0] v_out,
  output logic [X_W-1:0]    xr_out,
  output logic [X_W-1:0]    xg_out,
  output logic [X_W-1:0]    xb_out
);

  // stage 1: clamp, hue times six
  logic [UNIT_W-1:0] s1_s_r, s1_v_r;
  logic [2:0]        s1_sec_r;
  logic [HUE_W-1:0]  s1_f_r;
  logic [HUE_W+2:0]  h6;

  assign h6 = {2'b00, hue, 1'b0} + {1'b0, hue, 2'b00};

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_s_r   <= (saturation > UNIT_ONE) ? UNIT_ONE : saturation;
      s1_v_r   <= (brightness > UNIT_ONE) ? UNIT_ONE : brightness;
      s1_sec_r <= h6[HUE_W+2:HUE_W];
      s1_f_r   <= h6[HUE_W-1:0];
    end
  end

  // stage 2: s*f, s*(1-f) and (1-s)
  logic [UNIT_W-1:0] s2_v_r;
  logic [2:0]        s2_sec_r;
  logic [X_W-1:0]    s2_sf_r, s2_sg_r, s2_xp_r;
  logic [HUE_W:0]    g;
  logic [X_W-1:0]    sf_nxt, sg_nxt, xp_nxt;

  always_comb begin
    g      = {1'b1, {HUE_W{1'b0}}} - {1'b0, s1_f_r};
    sf_nxt = X_W'(s1_s_r) * X_W'(s1_f_r);
    sg_nxt = X_W'(s1_s_r) * X_W'(g);
    xp_nxt = X_W'(UNIT_ONE - s1_s_r) << HUE_W;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_v_r   <= s1_v_r;
      s2_sec_r <= s1_sec_r;
      s2_sf_r  <= sf_nxt;
      s2_sg_r  <= sg_nxt;
      s2_xp_r  <= xp_nxt;
    end
  end

  // stage 3: form q and t factors, route by sector
  // zero saturation needs no special path: every factor is then one
  logic [UNIT_W-1:0] s3_v_r;
  logic [X_W-1:0]    s3_xr_r, s3_xg_r, s3_xb_r;
  logic [X_W-1:0]    xq, xt;
  logic [X_W-1:0]    xr_nxt, xg_nxt, xb_nxt;

  always_comb begin
    xq = X_ONE - s2_sf_r;
    xt = X_ONE - s2_sg_r;
    unique case (sector_t'(s2_sec_r))
      SEC_R_TO_Y: begin xr_nxt = X_ONE;   xg_nxt = xt;      xb_nxt = s2_xp_r; end
      SEC_Y_TO_G: begin xr_nxt = xq;      xg_nxt = X_ONE;   xb_nxt = s2_xp_r; end
      SEC_G_TO_C: begin xr_nxt = s2_xp_r; xg_nxt = X_ONE;   xb_nxt = xt;      end
      SEC_C_TO_B: begin xr_nxt = s2_xp_r; xg_nxt = xq;      xb_nxt = X_ONE;   end
      SEC_B_TO_M: begin xr_nxt = xt;      xg_nxt = s2_xp_r; xb_nxt = X_ONE;   end
      default:    begin xr_nxt = X_ONE;   xg_nxt = s2_xp_r; xb_nxt = xq;      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_v_r  <= s2_v_r;
      s3_xr_r <= xr_nxt;
      s3_xg_r <= xg_nxt;
      s3_xb_r <= xb_nxt;
    end
  end

  assign v_out  = s3_v_r;
  assign xr_out = s3_xr_r;
  assign xg_out = s3_xg_r;
  assign xb_out = s3_xb_r;

endmodule

// ===== rtl/hsv2rgb_chan.sv =====
module hsv2rgb_chan
  import hsv2rgb_pkg::*;
(
  input  logic              clk,
  input  pipe_en_t          en,
  input  logic [UNIT_W-1:0] v,
  input  logic [X_W-1:0]    x,
  output logic [BYTE_W-1:0] chan
);

  logic [NUM_W-1:0]  prod_r;
  logic [NUM_W-1:0]  prod_nxt;
  logic [RND_W-1:0]  rnd;
  logic [BYTE_W-1:0] chan_r;

  // product is at most one in units of 2^-TOTAL_SHIFT, so it fits NUM_W
  assign prod_nxt = NUM_W'(NUM_W'(v) * NUM_W'(x));

  always_ff @(posedge clk) begin
    if (en.s4) begin
      prod_r <= prod_nxt;
    end
  end

  // times 255, add a half, keep the integer part
  assign rnd = {prod_r, {BYTE_W{1'b0}}} - RND_W'(prod_r) + RND_HALF;

  always_ff @(posedge clk) begin
    if (en.s5) begin
      chan_r <= rnd[TOTAL_SHIFT +: BYTE_W];
    end
  end

  assign chan = chan_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import hsv2rgb_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 420;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [HUE_W-1:0]  in_hue = '0;
  logic [UNIT_W-1:0] in_saturation = '0;
  logic [UNIT_W-1:0] in_brightness = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_red;
  logic [BYTE_W-1:0] out_green;
  logic [BYTE_W-1:0] out_blue;

  rgb_t        pending_rgb[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;

  hsv_to_rgb_converter_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // exact channel value in units of 2^-TOTAL_SHIFT, scaled to a byte, half up
  function automatic logic [BYTE_W-1:0] channel_byte(input longint unsigned num);
    longint unsigned r;
    r = (num * 255 + (64'd1 << (TOTAL_SHIFT - 1))) >> TOTAL_SHIFT;
    return (r > 255) ? 8'd255 : r[BYTE_W-1:0];
  endfunction

  function automatic rgb_t predict_rgb(input logic [HUE_W-1:0] h,
                                       input logic [UNIT_W-1:0] s_in,
                                       input logic [UNIT_W-1:0] v_in);
    longint unsigned one_q;
    longint unsigned span;
    longint unsigned s, v, h6, f, vn, pn, qn, tn, rn, gn, bn;
    sector_t         sec;
    rgb_t            rgb;
    one_q = 64'd1 << FRAC_BITS;
    span  = 64'd1 << HUE_W;
    s = (s_in > UNIT_ONE) ? one_q : longint'(s_in);
    v = (v_in > UNIT_ONE) ? one_q : longint'(v_in);
    vn = v * one_q * span;
    if (s == 0) begin
      rn = vn;
      gn = vn;
      bn = vn;
    end else begin
      h6  = longint'(h) * 6;
      sec = sector_t'(h6 >> HUE_W);
      f   = h6 & (span - 1);
      pn  = v * (one_q - s) * span;
      qn  = v * (one_q * span - s * f);
      tn  = v * (one_q * span - s * (span - f));
      case (sec)
        SEC_R_TO_Y: begin rn = vn; gn = tn; bn = pn; end
        SEC_Y_TO_G: begin rn = qn; gn = vn; bn = pn; end
        SEC_G_TO_C: begin rn = pn; gn = vn; bn = tn; end
        SEC_C_TO_B: begin rn = pn; gn = qn; bn = vn; end
        SEC_B_TO_M: begin rn = tn; gn = pn; bn = vn; end
        default:    begin rn = vn; gn = pn; bn = qn; end
      endcase
    end
    rgb.red   = channel_byte(rn);
    rgb.green = channel_byte(gn);
    rgb.blue  = channel_byte(bn);
    return rgb;
  endfunction

  // leaves valid high on return so back-to-back words need no extra edge
  task automatic send_pixel(input logic [HUE_W-1:0] h,
                            input logic [UNIT_W-1:0] s,
                            input logic [UNIT_W-1:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= h;
    in_saturation <= s;
    in_brightness <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rgb.push_back(predict_rgb(h, s, v));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  // mostly legal Q12 values, with gray, full and clamped values mixed in
  function automatic logic [UNIT_W-1:0] pick_unit();
    int unsigned kind;
    kind = $urandom_range(11);
    case (kind)
      0:       return '0;
      1:       return UNIT_ONE;
      2, 3:    return UNIT_W'($urandom_range(8191, 4097));
      default: return UNIT_W'($urandom_range(4096));
    endcase
  endfunction

  task automatic test_directed();
    send_idle_pct = 0;
    // primaries and secondaries, one per sector
    send_pixel(16'd0,     13'd4096, 13'd4096);
    send_pixel(16'd10923, 13'd4096, 13'd4096);
    send_pixel(16'd21846, 13'd4096, 13'd4096);
    send_pixel(16'd32768, 13'd4096, 13'd4096);
    send_pixel(16'd43691, 13'd4096, 13'd4096);
    send_pixel(16'd54614, 13'd4096, 13'd4096);
    // just below each sector boundary
    send_pixel(16'd10922, 13'd4096, 13'd4096);
    send_pixel(16'd21845, 13'd3000, 13'd4096);
    send_pixel(16'd32767, 13'd2048, 13'd4095);
    send_pixel(16'd43690, 13'd4095, 13'd2048);
    send_pixel(16'd54613, 13'd1,    13'd4096);
    // top of the hue range, sector five with f just below one
    send_pixel(16'hFFFF,  13'd4096, 13'd4096);
    send_pixel(16'hFFFF,  13'd8191, 13'd8191);
    // gray
    send_pixel(16'h1234,  13'd0,    13'd4096);
    send_pixel(16'hFFFF,  13'd0,    13'd2048);
    send_pixel(16'h8000,  13'd0,    13'd1);
    send_pixel(16'h0000,  13'd0,    13'd8191);
    // clamping above one, then near-zero and zero values
    send_pixel(16'h5555,  13'd4097, 13'd4097);
    send_pixel(16'hAAAA,  13'd8191, 13'd1000);
    send_pixel(16'h2AAA,  13'd1,    13'd1);
    send_pixel(16'h0000,  13'd0,    13'd0);
    send_pixel(16'hD555,  13'd4096, 13'd0);
    wait_drained();
  endtask

  task automatic test_random(input int unsigned n_pixels,
                             input int unsigned send_pct,
                             input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
    repeat (n_pixels) send_pixel(HUE_W'($urandom()), pick_unit(), pick_unit());
    wait_drained();
  endtask

  // long hold on the result side so the pipe fills and stalls its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_left <= 400;
    repeat (40) send_pixel(HUE_W'($urandom()), pick_unit(), pick_unit());
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // each accepted word must match the oldest pending colour
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rgb.size() == 0) begin
        $error("result word with no pixel pending");
        mismatch_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (out_red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_red);
          mismatch_count++;
        end
        if (out_green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_green);
          mismatch_count++;
        end
        if (out_blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_blue);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(RANDOM_PER_PHASE, 0, 0);
    test_random(RANDOM_PER_PHASE, 84, 0);
    test_random(RANDOM_PER_PHASE, 0, 84);
    test_random(RANDOM_PER_PHASE, 30, 30);
    recv_stall_pct <= 0;
    repeat (N_STAGES * 4) @(posedge clk);
    if (pending_rgb.size() != 0) begin
      $error("%0d pixels never produced a result", pending_rgb.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
